### hw/rtl/ps2mct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared widths, reset values and codes for the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int OUT_COORD_W    = 12;
    localparam int CFG_W          = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int BTN_W          = 3;

    localparam int POS_X_RESET    = 512;
    localparam int POS_Y_RESET    = 384;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd768;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GUI_ENABLED   = 2'd2;

    typedef logic [1:0] t_slot;

    localparam t_slot SLOT_HEAD = 2'd0;
    localparam t_slot SLOT_DX   = 2'd1;
    localparam t_slot SLOT_DY   = 2'd2;

endpackage
`default_nettype wire

### hw/rtl/ps2_mouse_cursor_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// Assembles three-word PS/2 mouse packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one mouse word per transfer
//   together with the render lock flag. Output channel (o_out_valid /
//   i_out_ready) gives the cursor position, the button state and the two GUI
//   flags for every word that is kept. A packet whose first word is zero is
//   dropped at its third word and the packet slot restarts; that word gives
//   no output.
//   A word passes one input register, then the slot step, the add and the
//   clamp feed the output register. Throughput is one word per cycle while
//   the receiver keeps up, set by the single pass through the add and clamp.
//   When the receiver stalls, the output register holds its word and the
//   input register takes at most one more word before o_in_ready drops.
//   Reset (synchronous, i_rst_n low) sets the slot to the third position,
//   clears the stored packet and buttons, centers the cursor at 512 / 384,
//   and loads width 1024, height 768 and GUI disabled.
//   Configuration writes (i_cfg_we) take effect at once; the user must make
//   them only while no word is in flight: the block does not enforce it.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker #(
    parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [ps2mct_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ps2mct_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [7:0]                          i_rx_byte,
    input  wire logic                                i_render_lock,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [ps2mct_pkg::OUT_COORD_W-1:0]       o_cursor_x,
    output logic [ps2mct_pkg::OUT_COORD_W-1:0]       o_cursor_y,
    output logic                                     o_left_pressed,
    output logic                                     o_right_pressed,
    output logic                                     o_middle_pressed,
    output logic                                     o_screen_dirty,
    output logic                                     o_gui_report
);

    localparam int CB = COORD_BITS;
    localparam int LW = (CB > ps2mct_pkg::CFG_W) ? CB : ps2mct_pkg::CFG_W;

    function automatic logic [CB-1:0] f_clamp(
        input logic signed [CB+1:0] v,
        input logic [CB-1:0]        top
    );
        logic [CB-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v[CB:0] > {1'b0, top}) begin
            res = top;
        end else begin
            res = v[CB-1:0];
        end
        return res;
    endfunction

    // configuration
    logic [ps2mct_pkg::CFG_W-1:0] r_width;
    logic [ps2mct_pkg::CFG_W-1:0] r_height;
    logic                         r_gui_en;

    // input register
    logic       r_in_valid;
    logic [7:0] r_rx_byte;
    logic       r_render_lock;

    // tracker state
    ps2mct_pkg::t_slot        r_slot;
    ps2mct_pkg::t_slot        n_slot;
    logic [7:0]               r_pkt0;
    logic [7:0]               n_pkt0;
    logic [7:0]               r_pkt1;
    logic [7:0]               n_pkt1;
    logic [CB-1:0]            r_pos_x;
    logic [CB-1:0]            n_pos_x;
    logic [CB-1:0]            r_pos_y;
    logic [CB-1:0]            n_pos_y;
    logic [ps2mct_pkg::BTN_W-1:0] r_buttons;
    logic [ps2mct_pkg::BTN_W-1:0] n_buttons;

    // output register
    logic                                r_out_valid;
    logic [ps2mct_pkg::OUT_COORD_W-1:0]  r_cursor_x;
    logic [ps2mct_pkg::OUT_COORD_W-1:0]  r_cursor_y;
    logic [ps2mct_pkg::BTN_W-1:0]        r_out_buttons;
    logic                                r_screen_dirty;
    logic                                r_gui_report;

    logic                     s_out_free;
    logic                     s_go;
    logic                     s_keep;
    logic signed [CB+1:0]     s_sum_x;
    logic signed [CB+1:0]     s_sum_y;
    logic [LW-1:0]            s_mask_w;
    logic [LW-1:0]            s_width_w;
    logic [LW-1:0]            s_height_w;
    logic [CB-1:0]            s_top_x;
    logic [CB-1:0]            s_top_y;

    assign s_out_free = !r_out_valid || i_out_ready;
    assign s_go       = r_in_valid && s_out_free;
    assign o_in_ready = !r_in_valid || s_go;

    assign s_mask_w   = LW'({CB{1'b1}});
    assign s_width_w  = LW'(r_width);
    assign s_height_w = LW'(r_height);
    assign s_top_x    = (s_width_w > s_mask_w) ? s_mask_w[CB-1:0] : s_width_w[CB-1:0];
    assign s_top_y    = (s_height_w > s_mask_w) ? s_mask_w[CB-1:0] : s_height_w[CB-1:0];

    assign s_sum_x = $signed({2'b00, r_pos_x}) + $signed({{(CB-6){r_pkt1[7]}}, r_pkt1});
    assign s_sum_y = $signed({2'b00, r_pos_y}) - $signed({{(CB-6){r_rx_byte[7]}}, r_rx_byte});

    always_comb begin
        n_slot    = r_slot;
        n_pkt0    = r_pkt0;
        n_pkt1    = r_pkt1;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_buttons = r_buttons;
        s_keep    = 1'b1;
        case (r_slot)
            ps2mct_pkg::SLOT_DX: begin
                n_pkt1 = r_rx_byte;
                n_slot = ps2mct_pkg::SLOT_DY;
            end
            ps2mct_pkg::SLOT_DY: begin
                n_slot = ps2mct_pkg::SLOT_HEAD;
                if (r_pkt0 == 8'h00) begin
                    s_keep = 1'b0;
                end else begin
                    n_buttons = r_pkt0[ps2mct_pkg::BTN_W-1:0];
                    n_pos_x   = f_clamp(s_sum_x, s_top_x);
                    n_pos_y   = f_clamp(s_sum_y, s_top_y);
                end
            end
            default: begin
                n_pkt0 = r_rx_byte;
                n_slot = ps2mct_pkg::SLOT_DX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ps2mct_pkg::WIDTH_RESET;
            r_height <= ps2mct_pkg::HEIGHT_RESET;
            r_gui_en <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ps2mct_pkg::REG_SCREEN_WIDTH:  r_width  <= i_cfg_wdata;
                ps2mct_pkg::REG_SCREEN_HEIGHT: r_height <= i_cfg_wdata;
                ps2mct_pkg::REG_GUI_ENABLED:   r_gui_en <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_rx_byte     <= i_rx_byte;
            r_render_lock <= i_render_lock;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= ps2mct_pkg::SLOT_DY;
            r_pkt0    <= '0;
            r_pkt1    <= '0;
            r_pos_x   <= CB'(ps2mct_pkg::POS_X_RESET);
            r_pos_y   <= CB'(ps2mct_pkg::POS_Y_RESET);
            r_buttons <= '0;
        end else if (s_go) begin
            r_slot    <= n_slot;
            r_pkt0    <= n_pkt0;
            r_pkt1    <= n_pkt1;
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_buttons <= n_buttons;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_go && s_keep) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_go && s_keep) begin
            r_cursor_x     <= ps2mct_pkg::OUT_COORD_W'(n_pos_x);
            r_cursor_y     <= ps2mct_pkg::OUT_COORD_W'(n_pos_y);
            r_out_buttons  <= n_buttons;
            r_screen_dirty <= !(r_gui_en && r_render_lock);
            r_gui_report   <= r_gui_en;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_cursor_x       = r_cursor_x;
    assign o_cursor_y       = r_cursor_y;
    assign o_left_pressed   = r_out_buttons[0];
    assign o_right_pressed  = r_out_buttons[1];
    assign o_middle_pressed = r_out_buttons[2];
    assign o_screen_dirty   = r_screen_dirty;
    assign o_gui_report     = r_gui_report;

`ifndef SYNTHESIS
    a_drop_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_go && !s_keep) |=> !o_out_valid)
        else $error("dropped packet produced an output word");

    a_head_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_go && r_slot == ps2mct_pkg::SLOT_HEAD) |=> (r_slot == ps2mct_pkg::SLOT_DX))
        else $error("slot did not advance after first packet word");

    a_buttons_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_go && r_slot == ps2mct_pkg::SLOT_DY) |=> $stable(r_buttons))
        else $error("buttons changed outside packet completion");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != 2'd3)
        else $error("packet slot left its range");
`endif

endmodule
`default_nettype wire

### dv/ps2mct_cursor_checker.sv
// ----------------------------------------------------------------------------
// ps2mct_cursor_checker
// Watches the word channels and the register port of the cursor tracker.
// Keeps its own packet slot, cursor and buttons, queues the cursor word that
// each accepted mouse byte should give, none for the last byte of a dropped
// packet, and compares every output word with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module ps2mct_cursor_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ps2mct_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ps2mct_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_ready,
    input  wire logic [7:0]                         i_rx_byte,
    input  wire logic                               i_render_lock,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_ready,
    input  wire logic [ps2mct_pkg::OUT_COORD_W-1:0] i_cursor_x,
    input  wire logic [ps2mct_pkg::OUT_COORD_W-1:0] i_cursor_y,
    input  wire logic                               i_left_pressed,
    input  wire logic                               i_right_pressed,
    input  wire logic                               i_middle_pressed,
    input  wire logic                               i_screen_dirty,
    input  wire logic                               i_gui_report,
    output int                                      o_fail_count,
    output int                                      o_pending
);

    typedef struct packed {
        logic [ps2mct_pkg::OUT_COORD_W-1:0] x;
        logic [ps2mct_pkg::OUT_COORD_W-1:0] y;
        logic                               left;
        logic                               right;
        logic                               middle;
        logic                               dirty;
        logic                               report;
    } t_cursor_word;

    logic [ps2mct_pkg::CFG_W-1:0]       width_lim  = ps2mct_pkg::WIDTH_RESET;
    logic [ps2mct_pkg::CFG_W-1:0]       height_lim = ps2mct_pkg::HEIGHT_RESET;
    logic                               gui_on     = 1'b0;
    ps2mct_pkg::t_slot                  slot       = ps2mct_pkg::SLOT_DY;
    logic [7:0]                         pkt [3];
    logic [ps2mct_pkg::OUT_COORD_W-1:0] cur_x      =
        ps2mct_pkg::OUT_COORD_W'(ps2mct_pkg::POS_X_RESET);
    logic [ps2mct_pkg::OUT_COORD_W-1:0] cur_y      =
        ps2mct_pkg::OUT_COORD_W'(ps2mct_pkg::POS_Y_RESET);
    logic [ps2mct_pkg::BTN_W-1:0]       btn        = '0;
    t_cursor_word                       cursor_words_due [$];
    int                                 fails      = 0;

    function automatic logic [ps2mct_pkg::OUT_COORD_W-1:0] clamp_to_screen(
        int                           v,
        logic [ps2mct_pkg::CFG_W-1:0] lim
    );
        if (v < 0) begin
            return '0;
        end
        if (v > int'(lim)) begin
            return lim;
        end
        return ps2mct_pkg::OUT_COORD_W'(v);
    endfunction

    task automatic take_mouse_byte(logic [7:0] b, logic lock);
        ps2mct_pkg::t_slot s;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        t_cursor_word      w;
        s = (slot == 2'd3) ? ps2mct_pkg::SLOT_HEAD : slot;
        pkt[s] = b;
        if (s == ps2mct_pkg::SLOT_DY && pkt[ps2mct_pkg::SLOT_HEAD] == 8'd0) begin
            slot = ps2mct_pkg::SLOT_HEAD;
            return;
        end
        if (s == ps2mct_pkg::SLOT_DY) begin
            btn   = pkt[ps2mct_pkg::SLOT_HEAD][ps2mct_pkg::BTN_W-1:0];
            dx    = pkt[ps2mct_pkg::SLOT_DX];
            dy    = pkt[ps2mct_pkg::SLOT_DY];
            cur_x = clamp_to_screen(int'(cur_x) + int'(dx), width_lim);
            cur_y = clamp_to_screen(int'(cur_y) - int'(dy), height_lim);
        end
        slot = (s == ps2mct_pkg::SLOT_DY) ? ps2mct_pkg::SLOT_HEAD
                                          : ps2mct_pkg::t_slot'(s + 2'd1);
        w.x      = cur_x;
        w.y      = cur_y;
        w.left   = btn[0];
        w.right  = btn[1];
        w.middle = btn[2];
        w.dirty  = !(gui_on && lock);
        w.report = gui_on;
        cursor_words_due.push_back(w);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cursor_word want;
        if (!i_rst_n) begin
            width_lim  = ps2mct_pkg::WIDTH_RESET;
            height_lim = ps2mct_pkg::HEIGHT_RESET;
            gui_on     = 1'b0;
            slot       = ps2mct_pkg::SLOT_DY;
            pkt        = '{default: 8'd0};
            cur_x      = ps2mct_pkg::OUT_COORD_W'(ps2mct_pkg::POS_X_RESET);
            cur_y      = ps2mct_pkg::OUT_COORD_W'(ps2mct_pkg::POS_Y_RESET);
            btn        = '0;
            cursor_words_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ps2mct_pkg::REG_SCREEN_WIDTH:  width_lim  = i_cfg_wdata;
                    ps2mct_pkg::REG_SCREEN_HEIGHT: height_lim = i_cfg_wdata;
                    ps2mct_pkg::REG_GUI_ENABLED:   gui_on     = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (cursor_words_due.size() == 0) begin
                    $display("%0t: word with none expected, actual x=%0d y=%0d", $time,
                             i_cursor_x, i_cursor_y);
                    fails++;
                end else begin
                    want = cursor_words_due.pop_front();
                    check_field("cursor_x", want.x, i_cursor_x);
                    check_field("cursor_y", want.y, i_cursor_y);
                    check_field("left_pressed", want.left, i_left_pressed);
                    check_field("right_pressed", want.right, i_right_pressed);
                    check_field("middle_pressed", want.middle, i_middle_pressed);
                    check_field("screen_dirty", want.dirty, i_screen_dirty);
                    check_field("gui_report", want.report, i_gui_report);
                end
            end
            if (i_in_valid && i_in_ready) begin
                take_mouse_byte(i_rx_byte, i_render_lock);
            end
        end
        o_fail_count <= fails;
        o_pending    <= cursor_words_due.size();
    end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the cursor tracker bench: drives mouse bytes in bursts, stalls the
// output side, reprograms the screen registers between phases and gives the
// verdict from the checker's failure count and its count of pending words.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [ps2mct_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 100;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               i_cfg_we      = 1'b0;
    logic [ps2mct_pkg::CFG_IDX_W-1:0]   i_cfg_index   = ps2mct_pkg::REG_SCREEN_WIDTH;
    logic [ps2mct_pkg::CFG_W-1:0]       i_cfg_wdata   = '0;
    logic                               i_in_valid    = 1'b0;
    logic [7:0]                         i_rx_byte     = 8'd0;
    logic                               i_render_lock = 1'b0;
    logic                               i_out_ready   = 1'b0;
    logic                               o_in_ready;
    logic                               o_out_valid;
    logic [ps2mct_pkg::OUT_COORD_W-1:0] o_cursor_x;
    logic [ps2mct_pkg::OUT_COORD_W-1:0] o_cursor_y;
    logic                               o_left_pressed;
    logic                               o_right_pressed;
    logic                               o_middle_pressed;
    logic                               o_screen_dirty;
    logic                               o_gui_report;
    int                                 fail_count;
    int                                 pending;

    int burst_left  = 1;
    int ready_mode  = 0;
    int mode_left   = 0;
    int run_left    = 0;
    int idle_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    ps2_mouse_cursor_tracker u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_render_lock    (i_render_lock),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cursor_x       (o_cursor_x),
        .o_cursor_y       (o_cursor_y),
        .o_left_pressed   (o_left_pressed),
        .o_right_pressed  (o_right_pressed),
        .o_middle_pressed (o_middle_pressed),
        .o_screen_dirty   (o_screen_dirty),
        .o_gui_report     (o_gui_report)
    );

    ps2mct_cursor_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_render_lock    (i_render_lock),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_cursor_x       (o_cursor_x),
        .i_cursor_y       (o_cursor_y),
        .i_left_pressed   (o_left_pressed),
        .i_right_pressed  (o_right_pressed),
        .i_middle_pressed (o_middle_pressed),
        .i_screen_dirty   (o_screen_dirty),
        .i_gui_report     (o_gui_report),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // receiver: always ready, coin-flip, or alternating runs of random length
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(20, 150);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (run_left == 0) begin
                    i_out_ready <= !i_out_ready;
                    run_left    <= $urandom_range(1, 12);
                end else begin
                    run_left <= run_left - 1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("ps2_mouse_cursor_tracker verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(logic [7:0] b, logic lk);
        int gap;
        i_in_valid    <= 1'b1;
        i_rx_byte     <= b;
        i_render_lock <= lk;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_packet(logic [7:0] head, logic [7:0] dx, logic [7:0] dy, logic lk);
        send_word(head, lk);
        send_word(dx, lk);
        send_word(dy, lk);
    endtask

    task automatic drop_valid();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [ps2mct_pkg::CFG_W-1:0] w,
                                logic [ps2mct_pkg::CFG_W-1:0] h, logic g);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ps2mct_pkg::REG_SCREEN_WIDTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_index <= ps2mct_pkg::REG_SCREEN_HEIGHT;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        i_cfg_index <= ps2mct_pkg::REG_GUI_ENABLED;
        i_cfg_wdata <= {(ps2mct_pkg::CFG_W-1)'($urandom_range(0, 2047)), g};
        @(posedge i_clk);
        i_cfg_index <= REG_SPARE;
        i_cfg_wdata <= ps2mct_pkg::CFG_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] drift_step(int drift);
        if (drift == 0 || $urandom_range(0, 1) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return (drift > 0) ? 8'($urandom_range(0, 127)) : 8'($urandom_range(128, 255));
    endfunction

    initial begin
        logic [ps2mct_pkg::CFG_W-1:0] w;
        logic [ps2mct_pkg::CFG_W-1:0] h;
        logic [7:0]                   head;
        int                           drift_x;
        int                           drift_y;
        int                           sent;
        int                           r;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(1, 40);

        // zero head at the first slot-two byte after reset: drop and restart
        send_word(8'h00, 1'b1);
        send_packet(8'h09, 8'h7F, 8'h80, 1'b0);
        send_packet(8'h07, 8'h80, 8'h7F, 1'b1);
        send_packet(8'h00, 8'h10, 8'hF0, 1'b0);
        send_packet(8'hFF, 8'hFF, 8'h01, 1'b1);
        send_packet(8'h02, 8'h00, 8'h00, 1'b0);
        send_packet(8'h04, 8'h01, 8'hFF, 1'b1);
        drop_valid();
        settle();

        program_regs(12'd1, 12'd1, 1'b1);
        send_packet(8'h01, 8'h7F, 8'h80, 1'b1);
        send_packet(8'h08, 8'h80, 8'h7F, 1'b0);
        drop_valid();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            case (p % 4)
                0: begin
                    w = 12'd4095;
                    h = 12'd4095;
                end
                1: begin
                    w = 12'd1;
                    h = 12'd1;
                end
                2: begin
                    w = ps2mct_pkg::CFG_W'($urandom_range(1, 4095));
                    h = ps2mct_pkg::CFG_W'($urandom_range(1, 4095));
                end
                default: begin
                    w = ps2mct_pkg::WIDTH_RESET;
                    h = ps2mct_pkg::HEIGHT_RESET;
                end
            endcase
            program_regs(w, h, 1'($urandom_range(0, 1)));
            drift_x = $urandom_range(0, 2) - 1;
            drift_y = $urandom_range(0, 2) - 1;
            sent = 0;
            while (sent < PHASE_WORDS) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    send_word(8'($urandom), 1'($urandom_range(0, 1)));
                    sent += 1;
                end else begin
                    head = (r < 12) ? 8'h00 : 8'($urandom_range(1, 255));
                    send_word(head, 1'($urandom_range(0, 1)));
                    send_word(drift_step(drift_x), 1'($urandom_range(0, 1)));
                    send_word(drift_step(drift_y), 1'($urandom_range(0, 1)));
                    sent += 3;
                end
            end
            drop_valid();
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("ps2_mouse_cursor_tracker verification clean");
        end else begin
            $display("ps2_mouse_cursor_tracker verification failed");
        end
        $finish;
    end

endmodule
